>>> src/zigio_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package zigio_pkg;

    localparam int ANALOG_CHANNELS = 4;
    localparam int MAX_CHANNELS    = 4;

    localparam logic [15:0] HEADER_LEN = 16'd15;
    localparam logic [15:0] ADDR_BYTES = 16'd8;
    localparam logic [15:0] INDEX_MAX  = 16'hFFFF;

    localparam logic [7:0] FRAME_TYPE_RESET = 8'd146;
    localparam logic [0:0] REG_FRAME_TYPE   = 1'b0;

    localparam logic [MAX_CHANNELS-1:0] CHANNEL_MASK =
        MAX_CHANNELS'((1 << ANALOG_CHANNELS) - 1);

    typedef enum logic [3:0] {
        CL_ADDR,
        CL_NWK_HI,
        CL_NWK_LO,
        CL_OPTIONS,
        CL_COUNT,
        CL_DMASK_HI,
        CL_DMASK_LO,
        CL_AMASK,
        CL_SAMPLE
    } t_class;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_WRONG_TYPE = 3'd1,
        ST_SHORT      = 3'd2,
        ST_COUNT      = 3'd3,
        ST_TRUNCATED  = 3'd4,
        ST_TRAILING   = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  ftype;
        logic        first;
        logic        last;
        t_class      cls;
        logic [15:0] pos;
        logic [15:0] total;
    } t_item;

    function automatic logic [2:0] popcount4(input logic [MAX_CHANNELS-1:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            n = n + {2'b00, v[i]};
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> src/zigio_front.sv
`timescale 1ns / 1ps
`default_nettype none
module zigio_front import zigio_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_frame_type,
    input  wire logic        i_last_byte,
    input  wire logic        i_full,
    output      logic        o_push,
    output      t_item       o_item
);

    logic [15:0] r_idx;
    logic [15:0] n_idx;
    logic [15:0] w_total;
    t_class      w_cls;

    assign o_push  = i_valid && !i_full;
    assign w_total = (r_idx == INDEX_MAX) ? INDEX_MAX : r_idx + 16'd1;

    always_comb begin
        priority if (r_idx < ADDR_BYTES) begin
            w_cls = CL_ADDR;
        end else if (r_idx == 16'd8) begin
            w_cls = CL_NWK_HI;
        end else if (r_idx == 16'd9) begin
            w_cls = CL_NWK_LO;
        end else if (r_idx == 16'd10) begin
            w_cls = CL_OPTIONS;
        end else if (r_idx == 16'd11) begin
            w_cls = CL_COUNT;
        end else if (r_idx == 16'd12) begin
            w_cls = CL_DMASK_HI;
        end else if (r_idx == 16'd13) begin
            w_cls = CL_DMASK_LO;
        end else if (r_idx == 16'd14) begin
            w_cls = CL_AMASK;
        end else begin
            w_cls = CL_SAMPLE;
        end
    end

    always_comb begin
        o_item.data  = i_data_byte;
        o_item.ftype = i_frame_type;
        o_item.first = (r_idx == 16'd0);
        o_item.last  = i_last_byte;
        o_item.cls   = w_cls;
        o_item.pos   = r_idx - HEADER_LEN;
        o_item.total = w_total;
    end

    always_comb begin
        n_idx = r_idx;
        if (o_push) begin
            n_idx = i_last_byte ? 16'd0 : w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 16'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule
`default_nettype wire

>>> src/zigio_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module zigio_queue import zigio_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output      logic  o_full,
    output      logic  o_empty,
    output      t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

>>> src/zigio_back.sv
`timescale 1ns / 1ps
`default_nettype none
module zigio_back import zigio_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_item       i_item,
    input  wire logic        i_empty,
    input  wire logic [7:0]  i_type_cfg,
    input  wire logic        i_stall,
    output      logic        o_pop,
    output      logic        o_valid,
    output      logic [2:0]  o_status,
    output      logic [63:0] o_source_address,
    output      logic [15:0] o_network_address,
    output      logic [7:0]  o_receive_options,
    output      logic [15:0] o_digital_mask,
    output      logic [7:0]  o_analog_mask,
    output      logic [15:0] o_digital_values,
    output      logic [63:0] o_analog_values
);

    // frame state
    logic [7:0]  r_latched, n_latched;
    logic [63:0] r_addr, n_addr;
    logic [15:0] r_nwk, n_nwk;
    logic [7:0]  r_opts, n_opts;
    logic        r_count_one, n_count_one;
    logic [15:0] r_dmask, n_dmask;
    logic [7:0]  r_amask, n_amask;
    logic [15:0] r_dword, n_dword;
    logic [15:0] r_aw [MAX_CHANNELS];
    logic [15:0] n_aw [MAX_CHANNELS];
    logic [7:0]  r_hold, n_hold;
    logic [1:0]  r_chan, n_chan;

    // result register
    logic        r_valid;
    t_status     r_status;
    logic [63:0] r_o_addr;
    logic [15:0] r_o_nwk;
    logic [7:0]  r_o_opts;
    logic [15:0] r_o_dmask;
    logic [7:0]  r_o_amask;
    logic [15:0] r_o_dval;
    logic [63:0] r_o_aval;

    logic                    w_do;
    logic                    w_emit;
    t_status                 w_status;
    logic [MAX_CHANNELS-1:0] w_en;
    logic [2:0]              w_pop_n;
    logic [15:0]             w_expected;
    logic [63:0]             w_aval;

    assign w_do   = !i_empty && (!i_item.last || !r_valid || !i_stall);
    assign w_emit = w_do && i_item.last;
    assign o_pop  = w_do;

    always_comb begin
        logic [15:0]             q;
        logic [14:0]             k;
        logic [MAX_CHANNELS-1:0] en_cur;
        logic [2:0]              pop_cur;
        logic [2:0]              seen;
        logic [1:0]              kth;
        logic                    found;
        logic                    digital_part;

        n_latched   = r_latched;
        n_addr      = r_addr;
        n_nwk       = r_nwk;
        n_opts      = r_opts;
        n_count_one = r_count_one;
        n_dmask     = r_dmask;
        n_amask     = r_amask;
        n_dword     = r_dword;
        n_aw        = r_aw;
        n_hold      = r_hold;
        n_chan      = r_chan;

        en_cur       = r_amask[MAX_CHANNELS-1:0] & CHANNEL_MASK;
        pop_cur      = popcount4(en_cur);
        digital_part = (r_dmask != 16'd0) && (i_item.pos < 16'd2);
        q            = (r_dmask != 16'd0) ? i_item.pos - 16'd2 : i_item.pos;
        k            = q[15:1];
        seen         = 3'd0;
        kth          = 2'd0;
        found        = 1'b0;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            if (en_cur[c] && !found) begin
                if (seen == k[2:0]) begin
                    kth   = 2'(c);
                    found = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end

        if (w_do) begin
            if (i_item.first) begin
                n_latched = i_item.ftype;
            end
            unique case (i_item.cls)
                CL_ADDR:     n_addr      = {r_addr[55:0], i_item.data};
                CL_NWK_HI:   n_nwk       = {i_item.data, 8'h00};
                CL_NWK_LO:   n_nwk       = {r_nwk[15:8], i_item.data};
                CL_OPTIONS:  n_opts      = i_item.data;
                CL_COUNT:    n_count_one = (i_item.data == 8'd1);
                CL_DMASK_HI: n_dmask     = {i_item.data, 8'h00};
                CL_DMASK_LO: n_dmask     = {r_dmask[15:8], i_item.data};
                CL_AMASK:    n_amask     = i_item.data;
                CL_SAMPLE: begin
                    if (digital_part) begin
                        if (!i_item.pos[0]) begin
                            n_hold = i_item.data;
                        end else begin
                            n_dword = {r_hold, i_item.data};
                        end
                    end else if (k < {12'd0, pop_cur}) begin
                        if (!q[0]) begin
                            n_chan = kth;
                            n_hold = i_item.data;
                        end else begin
                            n_aw[r_chan] = {r_hold, i_item.data};
                        end
                    end
                end
                default: n_hold = r_hold;
            endcase
        end
    end

    assign w_en       = n_amask[MAX_CHANNELS-1:0] & CHANNEL_MASK;
    assign w_pop_n    = popcount4(w_en);
    assign w_expected = HEADER_LEN + ((n_dmask != 16'd0) ? 16'd2 : 16'd0)
                      + {12'd0, w_pop_n, 1'b0};

    always_comb begin
        priority if (n_latched != i_type_cfg) begin
            w_status = ST_WRONG_TYPE;
        end else if (i_item.total < HEADER_LEN) begin
            w_status = ST_SHORT;
        end else if (!n_count_one) begin
            w_status = ST_COUNT;
        end else if (i_item.total < w_expected) begin
            w_status = ST_TRUNCATED;
        end else if (i_item.total > w_expected) begin
            w_status = ST_TRAILING;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        w_aval = 64'd0;
        for (int c = 0; c < ANALOG_CHANNELS; c++) begin
            if (w_en[c]) begin
                w_aval[16*c +: 16] = n_aw[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_latched   <= n_latched;
        r_addr      <= n_addr;
        r_nwk       <= n_nwk;
        r_opts      <= n_opts;
        r_count_one <= n_count_one;
        r_dmask     <= n_dmask;
        r_amask     <= n_amask;
        r_dword     <= n_dword;
        r_aw        <= n_aw;
        r_hold      <= n_hold;
        r_chan      <= n_chan;
        if (w_emit) begin
            r_status <= w_status;
            if (w_status == ST_OK) begin
                r_o_addr  <= n_addr;
                r_o_nwk   <= n_nwk;
                r_o_opts  <= n_opts;
                r_o_dmask <= n_dmask;
                r_o_amask <= n_amask;
                r_o_dval  <= (n_dmask != 16'd0) ? n_dword : 16'd0;
                r_o_aval  <= w_aval;
            end else begin
                r_o_addr  <= 64'd0;
                r_o_nwk   <= 16'd0;
                r_o_opts  <= 8'd0;
                r_o_dmask <= 16'd0;
                r_o_amask <= 8'd0;
                r_o_dval  <= 16'd0;
                r_o_aval  <= 64'd0;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_source_address  = r_o_addr;
    assign o_network_address = r_o_nwk;
    assign o_receive_options = r_o_opts;
    assign o_digital_mask    = r_o_dmask;
    assign o_analog_mask     = r_o_amask;
    assign o_digital_values  = r_o_dval;
    assign o_analog_values   = r_o_aval;

endmodule
`default_nettype wire

>>> src/zigbee_io_sample_frame_decoder.sv
`timescale 1ns / 1ps
// result path: a frame's last byte is written into the two-entry queue; the field
// update stage pops it, once a pending word is taken, and registers its result word
// throughput: one byte word per cycle while no result word is held by i_stall; the
// classify stage, the two-entry queue and the field update stage then run every cycle
// reset: synchronous, active low; clears the byte counter, queue and result valid,
// frame type register returns to 146
`default_nettype none
module zigbee_io_sample_frame_decoder import zigio_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_frame_type,
    input  wire logic        i_last_byte,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [2:0]  o_status,
    output      logic [63:0] o_source_address,
    output      logic [15:0] o_network_address,
    output      logic [7:0]  o_receive_options,
    output      logic [15:0] o_digital_mask,
    output      logic [7:0]  o_analog_mask,
    output      logic [15:0] o_digital_values,
    output      logic [63:0] o_analog_values,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic [7:0] r_type_cfg;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    t_item      w_front_item;
    t_item      w_queue_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_TYPE) ? {24'd0, r_type_cfg} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_cfg <= FRAME_TYPE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_TYPE) begin
            r_type_cfg <= pwdata[7:0];
        end
    end

    assign o_stall = w_full;

    zigio_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_frame_type (i_frame_type),
        .i_last_byte  (i_last_byte),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_item       (w_front_item)
    );

    zigio_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    zigio_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (w_queue_item),
        .i_empty           (w_empty),
        .i_type_cfg        (r_type_cfg),
        .i_stall           (i_stall),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_source_address  (o_source_address),
        .o_network_address (o_network_address),
        .o_receive_options (o_receive_options),
        .o_digital_mask    (o_digital_mask),
        .o_analog_mask     (o_analog_mask),
        .o_digital_values  (o_digital_values),
        .o_analog_values   (o_analog_values)
    );

    a_reset_no_word: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid right after reset");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (o_source_address == 64'd0 && o_analog_values == 64'd0 &&
             o_digital_mask == 16'd0))
        else $error("error word carries data");

    a_digital_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_digital_mask == 16'd0) |-> o_digital_values == 16'd0)
        else $error("digital values without digital mask");

    a_analog_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_analog_mask[0]) |-> o_analog_values[15:0] == 16'd0)
        else $error("analog channel 0 present while disabled");

endmodule
`default_nettype wire
